@@ src/wrl_pkg.sv @@
// ----------------------------------------------------------------------------
// wrl_pkg
// Shared constants, register codes and stage types of the white run filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wrl_pkg;

  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int LEN_W      = 10;
  localparam int TOT_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);
  localparam logic [TOT_W-1:0] TOT_MAX  = '1;

  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_LOW,
    REG_COL_HIGH,
    REG_ROW_LOW,
    REG_ROW_HIGH,
    REG_MIN_RUN,
    REG_VALUE_MIN,
    REG_SAT_MAX,
    REG_VERDICT_MIN
  } reg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] col_low;
    logic [COL_W-1:0] col_high;
    logic [ROW_W-1:0] row_low;
    logic [ROW_W-1:0] row_high;
    logic [LEN_W-1:0] min_run;
    logic [PIX_W-1:0] value_min;
    logic [PIX_W-1:0] sat_max;
    logic [TOT_W-1:0] verdict_min;
  } cfg_t;

  // Pixel with its raster position, held in the input register
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             end_row;
    logic             frame_end;
  } pix_t;

  // Classified pixel
  typedef struct packed {
    logic             white;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             end_row;
    logic             frame_end;
  } cls_t;

  // All results caused by one pixel
  typedef struct packed {
    logic             has_run;
    logic             has_verdict;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] start_col;
    logic [LEN_W-1:0] run_length;
    logic             run_kept;
    logic [TOT_W-1:0] kept_total;
    logic             stop_line;
  } event_t;

  // One result item
  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] start_col;
    logic [LEN_W-1:0] run_length;
    logic             run_kept;
    logic [TOT_W-1:0] kept_total;
    logic             stop_line;
  } res_t;

endpackage

`default_nettype wire

@@ src/wrl_cfg.sv @@
// ----------------------------------------------------------------------------
// wrl_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module wrl_cfg
  import wrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_low     <= COL_W'(160);
      cfg.col_high    <= COL_W'(479);
      cfg.row_low     <= ROW_W'(200);
      cfg.row_high    <= ROW_W'(383);
      cfg.min_run     <= LEN_W'(80);
      cfg.value_min   <= PIX_W'(210);
      cfg.sat_max     <= PIX_W'(50);
      cfg.verdict_min <= TOT_W'(80);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COL_LOW:     cfg.col_low     <= cfg_data[COL_W-1:0];
        REG_COL_HIGH:    cfg.col_high    <= cfg_data[COL_W-1:0];
        REG_ROW_LOW:     cfg.row_low     <= cfg_data[ROW_W-1:0];
        REG_ROW_HIGH:    cfg.row_high    <= cfg_data[ROW_W-1:0];
        REG_MIN_RUN:     cfg.min_run     <= cfg_data[LEN_W-1:0];
        REG_VALUE_MIN:   cfg.value_min   <= cfg_data[PIX_W-1:0];
        REG_SAT_MAX:     cfg.sat_max     <= cfg_data[PIX_W-1:0];
        REG_VERDICT_MIN: cfg.verdict_min <= cfg_data[TOT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/wrl_classify.sv @@
// ----------------------------------------------------------------------------
// wrl_classify
// Raster position counters, input register and white pixel test.
// ----------------------------------------------------------------------------
`default_nettype none

module wrl_classify
  import wrl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire logic [PIX_W-1:0] in_blue,
  input  wire logic [PIX_W-1:0] in_green,
  input  wire logic [PIX_W-1:0] in_red,
  input  wire logic             in_row_end,
  input  wire logic             in_frame_end,
  input  cfg_t                  cfg,
  output logic                  cls_valid,
  output cls_t                  cls
);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             end_row;
  logic             pix_valid;
  pix_t             pix;

  logic [PIX_W-1:0]   mx;
  logic [PIX_W-1:0]   mn;
  logic [PIX_W-1:0]   diff;
  logic [16:0]        sat_num;
  logic [16:0]        sat_prod;
  logic [17:0]        sat_den;
  logic               sat_ok;
  logic               in_win;
  cls_t               cls_next;

  assign end_row = in_row_end || in_frame_end || (col >= COL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      pix_valid <= 1'b0;
    end else if (adv) begin
      pix_valid <= in_valid;
      if (in_valid) begin
        if (in_frame_end) begin
          col <= '0;
          row <= '0;
        end else if (end_row) begin
          col <= '0;
          if (row < ROW_LAST) begin
            row <= row + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix.blue      <= in_blue;
      pix.green     <= in_green;
      pix.red       <= in_red;
      pix.col       <= col;
      pix.row       <= row;
      pix.end_row   <= end_row;
      pix.frame_end <= in_frame_end;
    end
  end

  // saturation <= s_max  <=>  510*(V-min) + V < 2*V*(s_max+1), for V > 0
  always_comb begin
    mx = pix.blue;
    mn = pix.blue;
    if (pix.green > mx) mx = pix.green;
    if (pix.red > mx)   mx = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.red < mn)   mn = pix.red;
    diff     = mx - mn;
    sat_num  = 17'(diff) * 17'd510 + 17'(mx);
    sat_prod = 17'(mx) * 17'({1'b0, cfg.sat_max} + 9'd1);
    sat_den  = {sat_prod, 1'b0};
    sat_ok   = (mx == '0) || ({1'b0, sat_num} < sat_den);
    in_win   = (pix.col >= cfg.col_low) && (pix.col <= cfg.col_high) &&
               (pix.row >= cfg.row_low) && (pix.row <= cfg.row_high);
    cls_next.white     = in_win && (mx >= cfg.value_min) && sat_ok;
    cls_next.col       = pix.col;
    cls_next.row       = pix.row;
    cls_next.end_row   = pix.end_row;
    cls_next.frame_end = pix.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (adv) begin
      cls_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls <= cls_next;
    end
  end

endmodule

`default_nettype wire

@@ src/wrl_run_track.sv @@
// ----------------------------------------------------------------------------
// wrl_run_track
// Run length tracking, run judgement and frame total.
// ----------------------------------------------------------------------------
`default_nettype none

module wrl_run_track
  import wrl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic cls_valid,
  input  cls_t      cls,
  input  cfg_t      cfg,
  output logic      push,
  output event_t    ev
);

  logic [LEN_W-1:0] run_count;
  logic [COL_W-1:0] run_start;
  logic [TOT_W-1:0] frame_kept;

  logic [LEN_W-1:0] count_next;
  logic [COL_W-1:0] start_next;
  logic             emit_run;
  logic             kept;
  logic [TOT_W:0]   sum;
  logic [TOT_W-1:0] total;
  logic             step;

  assign step = adv && cls_valid;

  always_comb begin
    count_next = run_count;
    start_next = run_start;
    if (cls.white) begin
      if (run_count == '0) start_next = cls.col;
      count_next = run_count + 1'b1;
    end
    emit_run = (!cls.white || cls.end_row) && (count_next != '0);
    kept     = count_next >= cfg.min_run;
    sum      = {1'b0, frame_kept} + ((emit_run && kept) ? (TOT_W+1)'(count_next) : '0);
    total    = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];

    ev.has_run     = emit_run;
    ev.has_verdict = cls.frame_end;
    ev.row         = cls.row;
    ev.start_col   = start_next;
    ev.run_length  = count_next;
    ev.run_kept    = kept;
    ev.kept_total  = total;
    ev.stop_line   = total >= cfg.verdict_min;
  end

  assign push = step && (emit_run || cls.frame_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count  <= '0;
      run_start  <= '0;
      frame_kept <= '0;
    end else if (step) begin
      run_start  <= start_next;
      run_count  <= emit_run ? '0 : count_next;
      frame_kept <= cls.frame_end ? '0 : total;
    end
  end

endmodule

`default_nettype wire

@@ src/wrl_out_queue.sv @@
// ----------------------------------------------------------------------------
// wrl_out_queue
// Two-entry queue of per-pixel results, sent one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module wrl_out_queue
  import wrl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  event_t    ev_in,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      out_kind,
  output logic      out_last,
  output res_t      out_res
);

  event_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       sent_run;
  event_t     head;
  logic       fire;
  logic       pop;
  logic       run_now;

  assign head      = mem[rd_ptr];
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign run_now   = head.has_run && !sent_run;
  assign out_kind  = run_now ? KIND_RUN : KIND_VERDICT;
  assign out_last  = !(run_now && head.has_verdict);
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  always_comb begin
    out_res = '0;
    if (run_now) begin
      out_res.row_index  = head.row;
      out_res.start_col  = head.start_col;
      out_res.run_length = head.run_length;
      out_res.run_kept   = head.run_kept;
    end else begin
      out_res.kept_total = head.kept_total;
      out_res.stop_line  = head.stop_line;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= ev_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      count    <= 2'd0;
      sent_run <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
      if (pop) begin
        sent_run <= 1'b0;
      end else if (fire) begin
        sent_run <= 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full result queue");

  a_not_last_is_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_kind == KIND_RUN))
    else $error("non-final item is not a run record");

  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    (fire && !out_last) |=> (out_valid && out_kind == KIND_VERDICT && out_last))
    else $error("verdict does not follow its run record");

endmodule

`default_nettype wire

@@ src/white_run_length_line_filter_top.sv @@
// ----------------------------------------------------------------------------
// white_run_length_line_filter_top
// White pixel run-length filter with per-frame stop-line verdict.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while s_tready is high. A pixel
// passes through an input register, a classify register and the run tracker
// into a two-entry result queue; the first result of a pixel is registered in
// that queue before m_tvalid rises for it. A pixel that ends both a run and the
// frame yields two items (run record, then verdict), which leave the queue one
// after the other; s_tready drops only while the result queue is full. No
// clearing pass after reset.
`default_nettype none

module white_run_length_line_filter_top
  import wrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata: blue[7:0], green[15:8], red[23:16]
  input  wire logic [23:0]           s_tdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic                  s_tlast,   // row_end
  input  wire logic                  s_tuser,   // frame_end
  // m_tdata: row_index[8:0], start_col[18:9], run_length[28:19], run_kept[29],
  //          kept_total[48:30], stop_line[49], zero[55:50]
  output logic [55:0]                m_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic                       m_tlast,   // last
  output logic                       m_tuser,   // kind
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   adv;
  logic   full;
  logic   cls_valid;
  cls_t   cls;
  logic   push;
  event_t ev;
  res_t   res;

  assign adv      = !full;
  assign s_tready = adv;

  wrl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wrl_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (s_tvalid),
    .in_blue      (s_tdata[7:0]),
    .in_green     (s_tdata[15:8]),
    .in_red       (s_tdata[23:16]),
    .in_row_end   (s_tlast),
    .in_frame_end (s_tuser),
    .cfg          (cfg),
    .cls_valid    (cls_valid),
    .cls          (cls)
  );

  wrl_run_track u_run_track (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cfg       (cfg),
    .push      (push),
    .ev        (ev)
  );

  wrl_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .ev_in     (ev),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_last  (m_tlast),
    .out_res   (res)
  );

  assign m_tdata = {6'b0, res.stop_line, res.kept_total, res.run_kept,
                    res.run_length, res.start_col, res.row_index};

endmodule

`default_nettype wire
